@@ rtl/core/vnacc_pkg.sv @@
// ---------------------------------------------------------------------------
// Vertex normal accumulator package
// Beat types, the command word passed from the front to the back end, and
// the fixed widths of the Q1.14 arithmetic.
// ---------------------------------------------------------------------------
package vnacc_pkg;

   localparam int IDX_W       = 10;   // vertex index width on the request
   localparam int POS_W       = 16;   // Q1.14 position component
   localparam int NRM_W       = 16;   // Q1.14 normal component
   localparam int FRAC_BITS   = 14;   // fraction bits of Q1.14
   localparam int MAG_BITS    = 24;   // magnitudes are scaled below 2^24
   localparam int EDGE_W      = POS_W + 1;
   localparam int CROSS_W     = 2 * EDGE_W + 1;
   localparam int RANGE_W     = 17;   // holds any vertex count up to 65536
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      REQ_STORE = 2'd0,
      REQ_FACE  = 2'd1,
      REQ_QUERY = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [IDX_W-1:0]        vertex_index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [IDX_W-1:0]        corner_a;
      logic [IDX_W-1:0]        corner_b;
      logic [IDX_W-1:0]        corner_c;
   } req_beat_type;

   typedef struct packed {
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
      logic                    normal_valid;
   } rsp_beat_type;

   // Classified command. Corners are already in winding order.
   typedef struct packed {
      req_kind_type            kind;
      logic                    out_of_range;
      logic [IDX_W-1:0]        vertex_index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [IDX_W-1:0]        corner_a;
      logic [IDX_W-1:0]        corner_b;
      logic [IDX_W-1:0]        corner_c;
   } cmd_type;

endpackage

@@ rtl/core/vnacc_front.sv @@
// ---------------------------------------------------------------------------
// Vertex normal accumulator front end
// Accepts request beats, range checks and classifies them, applies the
// winding register and queues the commands for the back end.
// ---------------------------------------------------------------------------
module vnacc_front #(
   parameter int VERTEX_COUNT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vnacc_pkg::req_beat_type req_beat,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   input  logic                   clearing,
   output logic                   cmd_valid,
   output vnacc_pkg::cmd_type     cmd,
   input  logic                   cmd_pop
);
   import vnacc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [RANGE_W-1:0] VC = RANGE_W'(VERTEX_COUNT);

   logic              reverse_winding_ff;
   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   cmd_type           entry_in;
   logic              push_in;
   logic              accept;
   logic              pop;

   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      return {{(RANGE_W-IDX_W){1'b0}}, idx} < VC;
   endfunction

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH)) || clearing;
   assign accept    = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      entry_in              = '0;
      push_in               = 1'b0;
      entry_in.vertex_index = req_beat.vertex_index;
      entry_in.pos_x        = req_beat.pos_x;
      entry_in.pos_y        = req_beat.pos_y;
      entry_in.pos_z        = req_beat.pos_z;
      entry_in.corner_b     = req_beat.corner_b;
      // Reversed winding swaps the first and last corner.
      entry_in.corner_a     = reverse_winding_ff ? req_beat.corner_c : req_beat.corner_a;
      entry_in.corner_c     = reverse_winding_ff ? req_beat.corner_a : req_beat.corner_c;
      case (req_beat.req_type)
         REQ_STORE: begin
            entry_in.kind = REQ_STORE;
            push_in       = in_range(req_beat.vertex_index);
         end
         REQ_FACE: begin
            entry_in.kind = REQ_FACE;
            push_in       = in_range(req_beat.corner_a) && in_range(req_beat.corner_b)
                            && in_range(req_beat.corner_c);
         end
         REQ_QUERY: begin
            entry_in.kind         = REQ_QUERY;
            entry_in.out_of_range = !in_range(req_beat.vertex_index);
            push_in               = 1'b1;
         end
         default: begin
            push_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_winding_ff <= 1'b0;
         wr_ptr_ff          <= '0;
         rd_ptr_ff          <= '0;
         count_ff           <= '0;
      end else begin
         if (csr_wr_en) begin
            reverse_winding_ff <= csr_wr_data;
         end
         if (accept && push_in) begin
            queue_ff[wr_ptr_ff] <= entry_in;
            wr_ptr_ff           <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         case ({accept && push_in, pop})
            2'b10:   count_ff <= count_ff + CNT_W'(1);
            2'b01:   count_ff <= count_ff - CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ rtl/core/vnacc_norm.sv @@
// ---------------------------------------------------------------------------
// Vertex normal accumulator normalizer
// Scales a signed 3-vector to a Q1.14 unit vector: shift down below 2^24,
// sum of squares, bit-serial square root, then three 15-step dividers.
// ---------------------------------------------------------------------------
module vnacc_norm #(
   parameter int VW = 35
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [2:0][VW-1:0]                  vec,
   output logic                                done,
   output logic                                ok,
   output logic [2:0][vnacc_pkg::NRM_W-1:0]    norm
);
   import vnacc_pkg::*;

   localparam int SQ_W   = 2 * MAG_BITS + 2;
   localparam int DIV_W  = MAG_BITS + FRAC_BITS + 1;
   localparam int QW     = FRAC_BITS + 1;
   localparam int STEP_W = $clog2(FRAC_BITS + 1);

   typedef enum logic [4:0] {
      N_IDLE  = 5'b00001,
      N_SHIFT = 5'b00010,
      N_SQ    = 5'b00100,
      N_SQRT  = 5'b01000,
      N_DIV   = 5'b10000
   } norm_state_type;

   norm_state_type          state_ff;
   logic [2:0][VW-1:0]      mag_ff;
   logic [2:0]              neg_ff;
   logic [1:0]              sq_cnt_ff;
   logic [2*MAG_BITS-1:0]   prod_ff;
   logic [SQ_W-1:0]         sum_ff;
   logic [SQ_W-1:0]         root_ff;
   logic [SQ_W-1:0]         bit_ff;
   logic [DIV_W-1:0]        dsh_ff;
   logic [2:0][DIV_W-1:0]   rem_ff;
   logic [2:0][QW-1:0]      q_ff;
   logic [STEP_W-1:0]       step_ff;
   logic                    done_ff;
   logic                    ok_ff;
   logic [2:0][VW-1:0]      mag_in;
   logic [SQ_W-1:0]         trial;
   logic [VW-1:0]           high_or;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = vec[i][VW-1] ? ('0 - vec[i]) : vec[i];
      end
      high_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      trial   = root_ff + bit_ff;
      for (int i = 0; i < 3; i++) begin
         norm[i] = neg_ff[i] ? ('0 - NRM_W'(q_ff[i])) : NRM_W'(q_ff[i]);
      end
   end

   assign done = done_ff;
   assign ok   = ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            N_IDLE: begin
               if (start) begin
                  mag_ff <= mag_in;
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= vec[i][VW-1];
                  end
                  q_ff <= '0;
                  if (mag_in == '0) begin
                     done_ff <= 1'b1;
                     ok_ff   <= 1'b0;
                  end else begin
                     state_ff <= N_SHIFT;
                  end
               end
            end
            N_SHIFT: begin
               if (high_or[VW-1:MAG_BITS] != '0) begin
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_ff[i] >> 1;
                  end
               end else begin
                  sq_cnt_ff <= '0;
                  sum_ff    <= '0;
                  state_ff  <= N_SQ;
               end
            end
            N_SQ: begin
               if (sq_cnt_ff != 2'd3) begin
                  prod_ff <= mag_ff[sq_cnt_ff][MAG_BITS-1:0] * mag_ff[sq_cnt_ff][MAG_BITS-1:0];
               end
               if (sq_cnt_ff != 2'd0) begin
                  sum_ff <= sum_ff + SQ_W'(prod_ff);
               end
               sq_cnt_ff <= sq_cnt_ff + 2'd1;
               if (sq_cnt_ff == 2'd3) begin
                  root_ff  <= '0;
                  bit_ff   <= SQ_W'(1) << (2 * MAG_BITS);
                  state_ff <= N_SQRT;
               end
            end
            N_SQRT: begin
               if (bit_ff != '0) begin
                  if (sum_ff >= trial) begin
                     sum_ff  <= sum_ff - trial;
                     root_ff <= (root_ff >> 1) + bit_ff;
                  end else begin
                     root_ff <= root_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end else begin
                  // Numerator m * 2^14 + len / 2 gives round-half-up.
                  for (int i = 0; i < 3; i++) begin
                     rem_ff[i] <= DIV_W'({mag_ff[i][MAG_BITS-1:0], {FRAC_BITS{1'b0}}})
                                  + DIV_W'(root_ff[MAG_BITS:1]);
                  end
                  dsh_ff   <= {root_ff[MAG_BITS:0], {FRAC_BITS{1'b0}}};
                  step_ff  <= STEP_W'(FRAC_BITS);
                  state_ff <= N_DIV;
               end
            end
            N_DIV: begin
               for (int i = 0; i < 3; i++) begin
                  if (rem_ff[i] >= dsh_ff) begin
                     rem_ff[i] <= rem_ff[i] - dsh_ff;
                     q_ff[i]   <= {q_ff[i][QW-2:0], 1'b1};
                  end else begin
                     q_ff[i]   <= {q_ff[i][QW-2:0], 1'b0};
                  end
               end
               dsh_ff  <= dsh_ff >> 1;
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  done_ff  <= 1'b1;
                  ok_ff    <= 1'b1;
                  state_ff <= N_IDLE;
               end
            end
            default: begin
               state_ff <= N_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/core/vnacc_back.sv @@
// ---------------------------------------------------------------------------
// Vertex normal accumulator back end
// Owns the position and sum memories, sequences stores, faces and queries,
// clears the sums after reset and holds the result register.
// ---------------------------------------------------------------------------
module vnacc_back #(
   parameter int VERTEX_COUNT = 1024,
   parameter int SUM_WIDTH    = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  vnacc_pkg::cmd_type      cmd,
   output logic                    cmd_pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output vnacc_pkg::rsp_beat_type rsp_beat
);
   import vnacc_pkg::*;

   localparam int AW = $clog2(VERTEX_COUNT);
   localparam int VW = (SUM_WIDTH > CROSS_W) ? SUM_WIDTH : CROSS_W;

   typedef enum logic [9:0] {
      B_CLEAR = 10'b0000000001,
      B_IDLE  = 10'b0000000010,
      B_POSRD = 10'b0000000100,
      B_EDGE  = 10'b0000001000,
      B_CROSS = 10'b0000010000,
      B_FNORM = 10'b0000100000,
      B_ACC   = 10'b0001000000,
      B_QRD   = 10'b0010000000,
      B_QNORM = 10'b0100000000,
      B_RESP  = 10'b1000000000
   } back_state_type;

   logic [2:0][POS_W-1:0]     pos_mem [VERTEX_COUNT];
   logic [2:0][SUM_WIDTH-1:0] sum_mem [VERTEX_COUNT];

   back_state_type               state_ff;
   cmd_type                      cmd_ff;
   logic [2:0]                   cnt_ff;
   logic                         phase_ff;
   logic [AW-1:0]                clear_addr_ff;
   logic [2:0][POS_W-1:0]        pos_rd_ff;
   logic [2:0][SUM_WIDTH-1:0]    sum_rd_ff;
   logic [2:0][POS_W-1:0]        corner_pos_ff [3];
   logic signed [EDGE_W-1:0]     e1_ff [3];
   logic signed [EDGE_W-1:0]     e2_ff [3];
   logic signed [2*EDGE_W-1:0]   prod_ff;
   logic signed [CROSS_W-1:0]    cross_ff [3];
   logic                         zero_ff;
   logic                         start_ff;
   logic                         rsp_valid_ff;
   rsp_beat_type                 rsp_ff;

   logic [IDX_W-1:0]             corner_sel;
   logic [AW-1:0]                corner_addr;
   logic signed [EDGE_W-1:0]     mul_a;
   logic signed [EDGE_W-1:0]     mul_b;
   logic [2:0]                   prev_cnt;
   logic                         pos_we;
   logic [AW-1:0]                sum_raddr;
   logic                         sum_we;
   logic [AW-1:0]                sum_waddr;
   logic [2:0][SUM_WIDTH-1:0]    sum_wdata;
   logic [2:0][SUM_WIDTH:0]      sum_ext;
   logic [2:0][VW-1:0]           norm_vec;
   logic                         norm_done;
   logic                         norm_ok;
   logic [2:0][NRM_W-1:0]        norm_n;
   logic                         rsp_load;
   logic [2:0][POS_W-1:0]        pos_wdata;

   vnacc_norm #(
      .VW (VW)
   ) u_norm (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .vec   (norm_vec),
      .done  (norm_done),
      .ok    (norm_ok),
      .norm  (norm_n)
   );

   always_comb begin
      case (cnt_ff)
         3'd0:    corner_sel = cmd_ff.corner_a;
         3'd1:    corner_sel = cmd_ff.corner_b;
         default: corner_sel = cmd_ff.corner_c;
      endcase
      corner_addr = AW'(corner_sel);

      case (cnt_ff)
         3'd0:    begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1:    begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2:    begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3:    begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4:    begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         default: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
      endcase
      prev_cnt = cnt_ff - 3'd1;

      pos_we       = (state_ff == B_IDLE) && cmd_valid && (cmd.kind == REQ_STORE);
      pos_wdata[0] = cmd.pos_x;
      pos_wdata[1] = cmd.pos_y;
      pos_wdata[2] = cmd.pos_z;

      sum_raddr = (state_ff == B_ACC) ? corner_addr : AW'(cmd_ff.vertex_index);
      for (int i = 0; i < 3; i++) begin
         sum_ext[i] = {sum_rd_ff[i][SUM_WIDTH-1], sum_rd_ff[i]}
                      + (SUM_WIDTH+1)'($signed(norm_n[i]));
         if (sum_ext[i][SUM_WIDTH] != sum_ext[i][SUM_WIDTH-1]) begin
            sum_wdata[i] = sum_ext[i][SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                                 : {1'b0, {(SUM_WIDTH-1){1'b1}}};
         end else begin
            sum_wdata[i] = sum_ext[i][SUM_WIDTH-1:0];
         end
         norm_vec[i] = (state_ff == B_FNORM) ? VW'(cross_ff[i])
                                             : VW'($signed(sum_rd_ff[i]));
      end
      if (state_ff == B_CLEAR) begin
         sum_wdata = '0;
      end
      sum_we    = (state_ff == B_CLEAR) || ((state_ff == B_ACC) && phase_ff);
      sum_waddr = (state_ff == B_CLEAR) ? clear_addr_ff : corner_addr;
      rsp_load  = (state_ff == B_RESP) && (!rsp_valid_ff || !rsp_stall);
   end

   assign cmd_pop   = (state_ff == B_IDLE) && cmd_valid;
   assign clearing  = (state_ff == B_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[AW'(cmd.vertex_index)] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[corner_addr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_CLEAR;
         clear_addr_ff <= '0;
         start_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_CLEAR: begin
               clear_addr_ff <= clear_addr_ff + AW'(1);
               if (clear_addr_ff == AW'(VERTEX_COUNT - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd;
                  cnt_ff   <= '0;
                  phase_ff <= 1'b0;
                  case (cmd.kind)
                     REQ_FACE: begin
                        state_ff <= B_POSRD;
                     end
                     REQ_QUERY: begin
                        zero_ff  <= cmd.out_of_range;
                        state_ff <= cmd.out_of_range ? B_RESP : B_QRD;
                     end
                     default: begin
                        state_ff <= B_IDLE;
                     end
                  endcase
               end
            end
            B_POSRD: begin
               if (cnt_ff != 3'd0) begin
                  corner_pos_ff[prev_cnt[1:0]] <= pos_rd_ff;
               end
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  state_ff <= B_EDGE;
               end
            end
            B_EDGE: begin
               for (int i = 0; i < 3; i++) begin
                  e1_ff[i]    <= EDGE_W'($signed(corner_pos_ff[1][i]))
                                 - EDGE_W'($signed(corner_pos_ff[0][i]));
                  e2_ff[i]    <= EDGE_W'($signed(corner_pos_ff[2][i]))
                                 - EDGE_W'($signed(corner_pos_ff[0][i]));
                  cross_ff[i] <= '0;
               end
               cnt_ff   <= '0;
               state_ff <= B_CROSS;
            end
            B_CROSS: begin
               if (cnt_ff != 3'd6) begin
                  prod_ff <= mul_a * mul_b;
               end
               if (cnt_ff != 3'd0) begin
                  if (prev_cnt[0]) begin
                     cross_ff[prev_cnt[2:1]] <= cross_ff[prev_cnt[2:1]] - CROSS_W'(prod_ff);
                  end else begin
                     cross_ff[prev_cnt[2:1]] <= cross_ff[prev_cnt[2:1]] + CROSS_W'(prod_ff);
                  end
               end
               if (cnt_ff == 3'd6) begin
                  start_ff <= 1'b1;
                  state_ff <= B_FNORM;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            B_FNORM: begin
               if (norm_done) begin
                  cnt_ff   <= '0;
                  phase_ff <= 1'b0;
                  state_ff <= norm_ok ? B_ACC : B_IDLE;
               end
            end
            B_ACC: begin
               phase_ff <= !phase_ff;
               if (phase_ff) begin
                  if (cnt_ff == 3'd2) begin
                     state_ff <= B_IDLE;
                  end else begin
                     cnt_ff <= cnt_ff + 3'd1;
                  end
               end
            end
            B_QRD: begin
               start_ff <= 1'b1;
               state_ff <= B_QNORM;
            end
            B_QNORM: begin
               if (norm_done) begin
                  state_ff <= B_RESP;
               end
            end
            B_RESP: begin
               if (rsp_load) begin
                  if (zero_ff) begin
                     rsp_ff <= '0;
                  end else begin
                     rsp_ff.normal_x     <= norm_n[0];
                     rsp_ff.normal_y     <= norm_n[1];
                     rsp_ff.normal_z     <= norm_n[2];
                     rsp_ff.normal_valid <= norm_ok;
                  end
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/core/vertex_normal_accumulator.sv @@
// ---------------------------------------------------------------------------
// Vertex normal accumulator
// Smooth per-vertex normals of a triangle mesh in Q1.14 fixed point.
// ---------------------------------------------------------------------------
// After reset the block sweeps the sum memory to zero, one vertex per cycle,
// and req_stall stays high until the sweep is done, so no beat is taken
// before then; the winding register can be written during that time. A
// store beat is written to the position memory as it leaves the queue. A
// face beat reads its three corners, forms the edge cross product with one
// shared 17x17 multiplier and then passes through the normalizer, followed
// by three read-modify-write updates of the sum memory; a degenerate face
// skips the updates. A query beat reads one sum and normalizes it before
// its result is loaded; a zero sum gives an invalid normal.
// In the normalizer, the vector is shifted down one bit per cycle until it
// is below 2^24, the three components are squared and summed, the square
// root is taken one result bit per cycle, and all three components are
// divided in parallel. The front end queues two beats ahead of the back
// end, and a finished result waits in its own register, so the request
// side keeps moving while a result is stalled until that queue fills.
// Faces with a zero cross product and faces or stores with an index of
// VERTEX_COUNT or more are dropped without a result; a query past the end
// returns an invalid, all-zero normal.
// ---------------------------------------------------------------------------
module vertex_normal_accumulator #(
   parameter int VERTEX_COUNT = 1024,
   parameter int SUM_WIDTH    = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  vnacc_pkg::req_beat_type req_beat,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output vnacc_pkg::rsp_beat_type rsp_beat,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data
);
   import vnacc_pkg::*;

   // Commands cross from the front end to the back end through the queue.
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   // High while the sum memory is being cleared after reset.
   logic    clearing;

   vnacc_front #(
      .VERTEX_COUNT (VERTEX_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .clearing    (clearing),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   vnacc_back #(
      .VERTEX_COUNT (VERTEX_COUNT),
      .SUM_WIDTH    (SUM_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

`ifndef SYNTHESIS
   // No request beat may be taken while the sums are still being cleared.
   a_stall_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_stall)
      else $error("request accepted during sum clearing");

   // An invalid normal carries zero components.
   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_beat.normal_valid) |->
         (rsp_beat.normal_x == '0 && rsp_beat.normal_y == '0 && rsp_beat.normal_z == '0))
      else $error("invalid normal with nonzero components");

   // A valid normal stays within plus or minus one in Q1.14.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beat.normal_valid) |->
         (rsp_beat.normal_x >= -16'sd16384 && rsp_beat.normal_x <= 16'sd16384 &&
          rsp_beat.normal_y >= -16'sd16384 && rsp_beat.normal_y <= 16'sd16384 &&
          rsp_beat.normal_z >= -16'sd16384 && rsp_beat.normal_z <= 16'sd16384))
      else $error("normal component out of unit range");
`endif

endmodule

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// Vertex normal accumulator regression
// Stores vertex positions, adds faces and queries smoothed normals, with
// both winding settings, and checks every answer against a predictor.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vnacc_pkg::*;

   localparam int VERTS    = 1024;
   localparam int SUM_BITS = 32;
   localparam int POOL     = 48;
   localparam int SETTLE   = 400;  // covers the longest faces still queued or in flight
   localparam int REQ_W    = $bits(req_beat_type);

   // Predictor and store of expected normals.
   class normal_board;
      logic signed [POS_W-1:0] pos_x_mem [VERTS];
      logic signed [POS_W-1:0] pos_y_mem [VERTS];
      logic signed [POS_W-1:0] pos_z_mem [VERTS];
      longint                  acc_x [VERTS];
      longint                  acc_y [VERTS];
      longint                  acc_z [VERTS];
      bit                      flip_winding;
      rsp_beat_type            pending_normals [$];
      int                      failures;

      function new();
         for (int i = 0; i < VERTS; i++) begin
            acc_x[i] = 0;
            acc_y[i] = 0;
            acc_z[i] = 0;
         end
         flip_winding = 0;
         failures     = 0;
      endfunction

      static function longint unsigned root_floor(longint unsigned s);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > s) b >>= 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // Scales a vector to Q1.14 unit length; a zero vector gives invalid.
      static function rsp_beat_type unit_normal(longint vx, longint vy, longint vz);
         longint unsigned mag [3];
         longint          comp [3];
         longint unsigned peak, len, q;
         logic signed [NRM_W-1:0] res [3];
         rsp_beat_type n;
         comp[0] = vx;
         comp[1] = vy;
         comp[2] = vz;
         peak = 0;
         for (int i = 0; i < 3; i++) begin
            mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
            if (mag[i] > peak) peak = mag[i];
            res[i] = '0;
         end
         n = '0;
         if (peak == 0) return n;
         while (peak >= (64'd1 << MAG_BITS)) begin
            peak >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
         end
         len = root_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
         for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + len / 2) / len;
            res[i] = comp[i] < 0 ? NRM_W'(-q) : NRM_W'(q);
         end
         n.normal_x     = res[0];
         n.normal_y     = res[1];
         n.normal_z     = res[2];
         n.normal_valid = 1'b1;
         return n;
      endfunction

      static function longint clamp_add(longint a, longint b);
         longint hi, r;
         hi = (longint'(1) << (SUM_BITS - 1)) - 1;
         r  = a + b;
         if (r > hi) r = hi;
         if (r < -hi - 1) r = -hi - 1;
         return r;
      endfunction

      function void add_face(int a, int b, int c);
         longint e1x, e1y, e1z, e2x, e2y, e2z;
         int t;
         int corners [3];
         rsp_beat_type n;
         if (flip_winding) begin
            t = a;
            a = c;
            c = t;
         end
         e1x = longint'(pos_x_mem[b]) - pos_x_mem[a];
         e1y = longint'(pos_y_mem[b]) - pos_y_mem[a];
         e1z = longint'(pos_z_mem[b]) - pos_z_mem[a];
         e2x = longint'(pos_x_mem[c]) - pos_x_mem[a];
         e2y = longint'(pos_y_mem[c]) - pos_y_mem[a];
         e2z = longint'(pos_z_mem[c]) - pos_z_mem[a];
         n = unit_normal(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
                         e1x * e2y - e1y * e2x);
         if (!n.normal_valid) return;  // degenerate face changes nothing
         corners = '{a, b, c};
         foreach (corners[k]) begin
            acc_x[corners[k]] = clamp_add(acc_x[corners[k]], n.normal_x);
            acc_y[corners[k]] = clamp_add(acc_y[corners[k]], n.normal_y);
            acc_z[corners[k]] = clamp_add(acc_z[corners[k]], n.normal_z);
         end
      endfunction

      function void note_request(req_beat_type b);
         case (b.req_type)
            REQ_STORE: begin
               pos_x_mem[b.vertex_index] = b.pos_x;
               pos_y_mem[b.vertex_index] = b.pos_y;
               pos_z_mem[b.vertex_index] = b.pos_z;
            end
            REQ_FACE: begin
               add_face(int'(b.corner_a), int'(b.corner_b), int'(b.corner_c));
            end
            REQ_QUERY: begin
               pending_normals.insert(pending_normals.size(),
                  unit_normal(acc_x[b.vertex_index], acc_y[b.vertex_index],
                              acc_z[b.vertex_index]));
            end
            default: begin
            end
         endcase
      endfunction

      function void check_normal(rsp_beat_type got);
         rsp_beat_type want;
         if (pending_normals.size() == 0) begin
            $display("%0t: unexpected normal beat %h", $time, got);
            failures++;
            return;
         end
         want = pending_normals.pop_front();
         if (got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
             got.normal_z !== want.normal_z || got.normal_valid !== want.normal_valid) begin
            $display("%0t: normal mismatch expected x=%0d y=%0d z=%0d v=%0b",
                     $time, want.normal_x, want.normal_y, want.normal_z, want.normal_valid);
            $display("%0t:                   actual x=%0d y=%0d z=%0d v=%0b",
                     $time, got.normal_x, got.normal_y, got.normal_z, got.normal_valid);
            failures++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_beat = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_beat;
   logic         csr_wr_en = 1'b0;
   logic         csr_wr_data = 1'b0;

   normal_board  board = new();
   bit           calm = 0;          // no idling in the closing phase
   bit           squeeze_armed = 0; // asks the receiver for one long hold-off
   int           pool_idx [POOL];

   vertex_normal_accumulator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Offers one beat. Valid stays high from one beat to the next unless a
   // random gap is drawn, so back-to-back beats are exercised as well.
   task automatic send_beat(req_beat_type b);
      if (!calm && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_beat  = b;
      do @(posedge clock); while (req_stall);
      board.note_request(b);
   endtask

   // Lets every outstanding query answer and every face retire before a
   // register write.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_winding(bit flip);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = flip;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      board.flip_winding = flip;
   endtask

   function automatic req_beat_type make_store(int idx, int x, int y, int z);
      req_beat_type b;
      b = '0;
      b.req_type     = REQ_STORE;
      b.vertex_index = IDX_W'(idx);
      b.pos_x        = POS_W'(x);
      b.pos_y        = POS_W'(y);
      b.pos_z        = POS_W'(z);
      return b;
   endfunction

   function automatic req_beat_type make_face(int a, int b, int c);
      req_beat_type r;
      r = '0;
      r.req_type = REQ_FACE;
      r.corner_a = IDX_W'(a);
      r.corner_b = IDX_W'(b);
      r.corner_c = IDX_W'(c);
      return r;
   endfunction

   function automatic req_beat_type make_query(int idx);
      req_beat_type r;
      r = '0;
      r.req_type     = REQ_QUERY;
      r.vertex_index = IDX_W'(idx);
      return r;
   endfunction

   // One mesh phase: every pool vertex is placed first so that faces only
   // ever read written positions, then a random mix of edits, faces and
   // queries follows, with some noise beats.
   task automatic run_mesh_phase(int beats);
      req_beat_type b;
      int           pick;
      for (int i = 0; i < POOL; i++) begin
         pool_idx[i] = $urandom_range(0, VERTS - 1);
         send_beat(make_store(pool_idx[i], $urandom, $urandom, $urandom));
      end
      for (int i = 0; i < beats; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            b = make_store(pool_idx[$urandom_range(0, POOL - 1)],
                           $urandom, $urandom, $urandom);
         end else if (pick < 60) begin
            b = make_face(pool_idx[$urandom_range(0, POOL - 1)],
                          pool_idx[$urandom_range(0, POOL - 1)],
                          pool_idx[$urandom_range(0, POOL - 1)]);
         end else if (pick < 64) begin
            // A repeated corner makes the face degenerate.
            b = make_face(pool_idx[i % POOL], pool_idx[i % POOL],
                          pool_idx[$urandom_range(0, POOL - 1)]);
         end else if (pick < 92) begin
            b = make_query(pool_idx[$urandom_range(0, POOL - 1)]);
         end else if (pick < 97) begin
            b = make_query($urandom_range(0, VERTS - 1));
         end else begin
            // Unused request code with random payload; it must be ignored.
            b = REQ_W'({$urandom, $urandom, $urandom});
            b.req_type = 2'd3;
         end
         send_beat(b);
      end
   endtask

   // Receiver: random stall bursts, one long hold-off to back the block up
   // into its input, and a steady ready state in the closing phase.
   initial begin
      int burst;
      int idle;
      burst = 0;
      idle  = 0;
      forever begin
         @(negedge clock);
         if (squeeze_armed && board.pending_normals.size() != 0) begin
            squeeze_armed = 0;
            rsp_stall = 1'b1;
            repeat (600) @(negedge clock);
         end
         if (calm) begin
            rsp_stall = 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_stall = 1'b1;
         end else if (idle > 0) begin
            idle--;
            rsp_stall = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 3) - 1;
            rsp_stall = 1'b1;
         end else begin
            idle = $urandom_range(0, 30);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_normal(rsp_beat);
      end
   end

   initial begin
      #40ms;
      $display("vertex_normal_accumulator regression: fail");
      $finish;
   end

   initial begin
      req_beat_type junk;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_winding(1'b0);

      // Directed part: axis vectors, coordinate extremes, all-ones indices,
      // degenerate and collinear faces, empty sums and the unused code.
      send_beat(make_store(0, 0, 0, 0));
      send_beat(make_store(1, 16384, 0, 0));
      send_beat(make_store(2, 0, 16384, 0));
      send_beat(make_store(1023, -32768, 32767, -32768));
      send_beat(make_store(512, 32767, -32768, 32767));
      send_beat(make_store(3, 32767, 0, 0));
      send_beat(make_face(0, 1, 2));
      send_beat(make_face(0, 1, 1023));
      send_beat(make_face(1023, 512, 2));
      send_beat(make_face(0, 0, 1));
      send_beat(make_face(0, 1, 3));
      send_beat(make_face(1023, 1023, 1023));
      junk = '1;
      send_beat(junk);
      send_beat(make_query(0));
      send_beat(make_query(1));
      send_beat(make_query(1023));
      send_beat(make_query(512));
      send_beat(make_query(3));
      send_beat(make_query(5));
      drain();
      write_winding(1'b1);
      send_beat(make_face(0, 1, 2));
      send_beat(make_query(0));
      send_beat(make_query(2));
      drain();

      run_mesh_phase(260);
      drain();
      write_winding(1'b0);
      squeeze_armed = 1;
      run_mesh_phase(260);
      drain();
      write_winding(1'b1);
      run_mesh_phase(260);
      drain();
      write_winding(1'b0);
      calm = 1;
      run_mesh_phase(300);

      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (board.failures == 0) begin
         $display("vertex_normal_accumulator regression: pass");
      end else begin
         $display("vertex_normal_accumulator regression: fail");
      end
      $finish;
   end
endmodule

@@ vertex_normal_accumulator.f @@
rtl/core/vnacc_pkg.sv
rtl/core/vnacc_front.sv
rtl/core/vnacc_norm.sv
rtl/core/vnacc_back.sv
rtl/core/vertex_normal_accumulator.sv
verif/tb_top.sv
